[rtl/hbpwm_pkg.sv]
package hbpwm_pkg;

  localparam int LvlW   = 15;
  localparam int DutyW  = 16;
  localparam int GuardW = 16;
  localparam int PulseW = 10;
  localparam int ProdW  = 2 * LvlW;
  localparam int CntW   = $clog2(ProdW);

  localparam logic [1:0] MODE_STOP = 2'd0;
  localparam logic [1:0] MODE_FWD  = 2'd1;
  localparam logic [1:0] MODE_BWD  = 2'd2;
  localparam logic [1:0] MODE_RSVD = 2'd3;

  localparam logic [1:0] DIR_ZERO = 2'b00;
  localparam logic [1:0] DIR_FWD  = 2'b01;
  localparam logic [1:0] DIR_BWD  = 2'b11;

  localparam logic [1:0] CFG_SWAP  = 2'd0;
  localparam logic [1:0] CFG_MIN   = 2'd1;
  localparam logic [1:0] CFG_MAX   = 2'd2;
  localparam logic [1:0] CFG_GUARD = 2'd3;

  localparam logic [PulseW-1:0] PULSE_FULL_US = PulseW'(1000);
  localparam logic [LvlW-1:0]   MAX_LEVEL_RST = LvlW'(255);
  localparam logic [CntW-1:0]   DIV_LAST      = CntW'(ProdW - 1);

  typedef struct packed {
    logic load;
    logic emit_guard;
    logic mul_remap;
    logic mul_pulse;
    logic div_step;
    logic adj;
    logic emit_final;
  } dp_cmd_t;

  typedef struct packed {
    logic guard_pend;
    logic remap_en;
    logic mx_zero;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/hbridge_pwm_command_mapper_core.sv]
// H-bridge command mapper. Each accepted command gives one final beat (pins, pulse_us,
// direction), preceded by an all-off guard beat carrying hold_us when the requested mode
// changes and guard_time_us is nonzero. One command is in work at a time; the next is
// taken once the final beat has been loaded into the output register, which may still be
// waiting on out_ready. Work time is set by a shared 30-step restoring divider, run twice
// when min_level remaps the duty, once without remap, and skipped when max_level is 0,
// plus any wait for the output register. Configuration writes are registered and
// must only be made while no command is in work.
module hbridge_pwm_command_mapper_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [hbpwm_pkg::GuardW-1:0] cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         req_type,
  input  logic [1:0]                   drive_mode,
  input  logic signed [hbpwm_pkg::DutyW-1:0] duty_request,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         pin_a,
  output logic                         pin_b,
  output logic [hbpwm_pkg::PulseW-1:0] pulse_us,
  output logic signed [1:0]            direction,
  output logic [hbpwm_pkg::GuardW-1:0] hold_us,
  output logic                         last_result
);
  import hbpwm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  hbpwm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  hbpwm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_type     (req_type),
    .drive_mode   (drive_mode),
    .duty_request (duty_request),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pin_a        (pin_a),
    .pin_b        (pin_b),
    .pulse_us     (pulse_us),
    .direction    (direction),
    .hold_us      (hold_us),
    .last_result  (last_result)
  );

endmodule

[rtl/hbpwm_dp.sv]
module hbpwm_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  hbpwm_pkg::dp_cmd_t           cmd,
  output hbpwm_pkg::dp_status_t        status,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [hbpwm_pkg::GuardW-1:0] cfg_data,
  input  logic                         req_type,
  input  logic [1:0]                   drive_mode,
  input  logic signed [hbpwm_pkg::DutyW-1:0] duty_request,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         pin_a,
  output logic                         pin_b,
  output logic [hbpwm_pkg::PulseW-1:0] pulse_us,
  output logic signed [1:0]            direction,
  output logic [hbpwm_pkg::GuardW-1:0] hold_us,
  output logic                         last_result
);
  import hbpwm_pkg::*;

  logic              swap_direction;
  logic [LvlW-1:0]   min_level;
  logic [LvlW-1:0]   max_level;
  logic [GuardW-1:0] guard_time_us;

  logic [1:0]        previous_mode;
  logic [1:0]        cur_dir;
  logic [1:0]        mode_act;
  logic              guard_pend;
  logic [LvlW-1:0]   mag;
  logic [ProdW-1:0]  quo;
  logic [LvlW-1:0]   rem;
  logic [CntW-1:0]   cnt;

  logic              neg;
  logic [DutyW-1:0]  mag_raw;
  logic [LvlW-1:0]   mag_clamp;
  logic [LvlW-1:0]   mn_eff;
  logic [1:0]        mode_req;
  logic [1:0]        mode_sw;
  logic [ProdW-1:0]  prod_remap;
  logic [ProdW-1:0]  prod_pulse;
  logic [LvlW:0]     trial;
  logic              ge;
  logic [PulseW-1:0] pulse_fin;

  always_comb begin
    neg       = duty_request[DutyW-1];
    mag_raw   = neg ? DutyW'(-duty_request) : DutyW'(duty_request);
    mag_clamp = (mag_raw > DutyW'(max_level)) ? max_level : mag_raw[LvlW-1:0];
    mn_eff    = (min_level > max_level) ? max_level : min_level;

    if (req_type) begin
      if (duty_request == '0) mode_req = MODE_STOP;
      else mode_req = neg ? MODE_BWD : MODE_FWD;
    end else begin
      mode_req = (drive_mode == MODE_RSVD) ? MODE_STOP : drive_mode;
    end

    mode_sw = mode_req;
    if (swap_direction) begin
      if (mode_req == MODE_FWD) mode_sw = MODE_BWD;
      else if (mode_req == MODE_BWD) mode_sw = MODE_FWD;
    end

    prod_remap = ProdW'(mag) * ProdW'(max_level - mn_eff);
    prod_pulse = ProdW'(mag) * ProdW'(PULSE_FULL_US);

    // restoring divide by max_level, one quotient bit a cycle
    trial = {rem, quo[ProdW-1]};
    ge    = trial >= {1'b0, max_level};

    pulse_fin = status.mx_zero ? '0 : quo[PulseW-1:0];
  end

  assign status.guard_pend = guard_pend;
  assign status.remap_en   = (mn_eff != '0) && (mag != '0);
  assign status.mx_zero    = (max_level == '0);
  assign status.div_last   = (cnt == DIV_LAST);
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      swap_direction <= 1'b0;
      min_level      <= '0;
      max_level      <= MAX_LEVEL_RST;
      guard_time_us  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SWAP:  swap_direction <= cfg_data[0];
        CFG_MIN:   min_level      <= cfg_data[LvlW-1:0];
        CFG_MAX:   max_level      <= cfg_data[LvlW-1:0];
        CFG_GUARD: guard_time_us  <= cfg_data;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_mode <= MODE_STOP;
      guard_pend    <= 1'b0;
    end else if (cmd.load) begin
      previous_mode <= mode_req;
      guard_pend    <= (guard_time_us != '0) && (mode_req != previous_mode);
    end else if (cmd.emit_guard) begin
      guard_pend    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_act <= mode_sw;
      mag      <= mag_clamp;
    end else if (cmd.adj) begin
      mag      <= quo[LvlW-1:0] + mn_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_remap || cmd.mul_pulse) begin
      quo <= cmd.mul_remap ? prod_remap : prod_pulse;
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? LvlW'(trial - {1'b0, max_level}) : trial[LvlW-1:0];
      quo <= {quo[ProdW-2:0], ge};
      cnt <= cnt + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_dir   <= DIR_ZERO;
    end else begin
      out_valid <= cmd.emit_guard || cmd.emit_final || (out_valid && !out_ready);
      if (cmd.emit_final) begin
        case (mode_act)
          MODE_FWD: cur_dir <= DIR_FWD;
          MODE_BWD: cur_dir <= DIR_BWD;
          default:  cur_dir <= DIR_ZERO;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_guard) begin
      pin_a       <= 1'b0;
      pin_b       <= 1'b0;
      pulse_us    <= '0;
      direction   <= cur_dir;
      hold_us     <= guard_time_us;
      last_result <= 1'b0;
    end else if (cmd.emit_final) begin
      hold_us     <= '0;
      last_result <= 1'b1;
      case (mode_act)
        MODE_FWD: begin
          pin_a     <= 1'b1;
          pin_b     <= 1'b0;
          pulse_us  <= pulse_fin;
          direction <= DIR_FWD;
        end
        MODE_BWD: begin
          pin_a     <= 1'b0;
          pin_b     <= 1'b1;
          pulse_us  <= pulse_fin;
          direction <= DIR_BWD;
        end
        default: begin
          pin_a     <= 1'b0;
          pin_b     <= 1'b0;
          pulse_us  <= '0;
          direction <= DIR_ZERO;
        end
      endcase
    end
  end

  a_pulse_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pulse_us <= PULSE_FULL_US)
    else $error("pulse beyond full scale");

  a_guard_off: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_result) |-> (!pin_a && !pin_b && pulse_us == '0))
    else $error("guard beat not all-off");

  a_pins_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(pin_a && pin_b))
    else $error("both bridge pins high");

endmodule

[rtl/hbpwm_ctrl.sv]
module hbpwm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hbpwm_pkg::dp_status_t status,
  output hbpwm_pkg::dp_cmd_t    cmd
);
  import hbpwm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GUARD = 3'd1;
  localparam logic [2:0] S_MUL1  = 3'd2;
  localparam logic [2:0] S_DIV1  = 3'd3;
  localparam logic [2:0] S_ADJ   = 3'd4;
  localparam logic [2:0] S_MUL2  = 3'd5;
  localparam logic [2:0] S_DIV2  = 3'd6;
  localparam logic [2:0] S_FINAL = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] route;

  assign in_ready = (state == S_IDLE);

  // skip the remap when min is zero or the duty is zero, and both divides on zero max
  assign route = status.remap_en ? S_MUL1 : (status.mx_zero ? S_FINAL : S_MUL2);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_GUARD;
        end
      end
      S_GUARD: begin
        if (!status.guard_pend || status.out_free) begin
          cmd.emit_guard = status.guard_pend;
          state_next     = route;
        end
      end
      S_MUL1: begin
        cmd.mul_remap = 1'b1;
        state_next    = S_DIV1;
      end
      S_DIV1: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_ADJ;
      end
      S_ADJ: begin
        cmd.adj    = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_pulse = 1'b1;
        state_next    = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_next = S_FINAL;
      end
      S_FINAL: begin
        if (status.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_guard || cmd.emit_final) |-> status.out_free)
    else $error("output register overwritten");

  a_accept_guard: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == S_GUARD)
    else $error("accepted beat did not enter guard check");

  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV1 && status.div_last) |=> state == S_ADJ)
    else $error("remap divide did not finish");

endmodule

[tb/tb_hbridge_pwm_command_mapper_core.sv]
`timescale 1ns / 100ps

module tb_hbridge_pwm_command_mapper_core;
  import hbpwm_pkg::*;

  typedef struct packed {
    logic        req_type;
    logic [1:0]  drive_mode;
    logic [15:0] duty;
  } motor_cmd_t;

  typedef struct packed {
    logic        pin_a;
    logic        pin_b;
    logic [9:0]  pulse_us;
    logic [1:0]  direction;
    logic [15:0] hold_us;
    logic        last_result;
  } bridge_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = CFG_SWAP;
  logic [GuardW-1:0]   cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                req_type = 1'b0;
  logic [1:0]          drive_mode = MODE_STOP;
  logic signed [DutyW-1:0] duty_request = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                pin_a;
  logic                pin_b;
  logic [PulseW-1:0]   pulse_us;
  logic signed [1:0]   direction;
  logic [GuardW-1:0]   hold_us;
  logic                last_result;

  hbridge_pwm_command_mapper_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .drive_mode   (drive_mode),
    .duty_request (duty_request),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pin_a        (pin_a),
    .pin_b        (pin_b),
    .pulse_us     (pulse_us),
    .direction    (direction),
    .hold_us      (hold_us),
    .last_result  (last_result)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #12000000;
    $display("== FAIL ==");
    $finish;
  end

  // register shadows and mapper state
  logic        swap_en = 1'b0;
  logic [14:0] lvl_min = 15'd0;
  logic [14:0] lvl_max = MAX_LEVEL_RST;
  logic [15:0] guard_us = 16'd0;
  logic [1:0]  last_req_mode = MODE_STOP;
  logic [1:0]  last_dir = DIR_ZERO;

  motor_cmd_t   cmd_backlog[$];
  bridge_beat_t beats_due[$];
  motor_cmd_t   cur_cmd;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_cnt = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  function automatic void map_command(motor_cmd_t c);
    logic [1:0]  mode;
    logic [1:0]  actual;
    logic        neg;
    int unsigned mag;
    int unsigned mx;
    int unsigned mn;
    int unsigned pulse;
    bridge_beat_t b;
    neg = c.duty[15];
    mag = neg ? (32'h10000 - {16'h0, c.duty}) : {16'h0, c.duty};
    mode = c.drive_mode;
    if (c.req_type) begin
      if (c.duty == 16'h0) mode = MODE_STOP;
      else mode = neg ? MODE_BWD : MODE_FWD;
    end
    if (mode == MODE_RSVD) mode = MODE_STOP;

    if (guard_us != 0 && mode != last_req_mode) begin
      b = '{pin_a: 1'b0, pin_b: 1'b0, pulse_us: 10'd0, direction: last_dir,
            hold_us: guard_us, last_result: 1'b0};
      beats_due.push_back(b);
    end
    last_req_mode = mode;

    actual = mode;
    if (swap_en) begin
      if (mode == MODE_FWD) actual = MODE_BWD;
      else if (mode == MODE_BWD) actual = MODE_FWD;
    end

    mx = lvl_max;
    mn = (lvl_min > lvl_max) ? lvl_max : lvl_min;
    pulse = 0;
    if (mag > mx) mag = mx;
    if (mn > 0 && mag > 0 && mx > 0) mag = mag * (mx - mn) / mx + mn;
    if (mx > 0) pulse = mag * 1000 / mx;

    b.hold_us = 16'd0;
    b.last_result = 1'b1;
    case (actual)
      MODE_FWD: begin
        b.pin_a = 1'b1; b.pin_b = 1'b0; b.pulse_us = pulse[9:0]; b.direction = DIR_FWD;
      end
      MODE_BWD: begin
        b.pin_a = 1'b0; b.pin_b = 1'b1; b.pulse_us = pulse[9:0]; b.direction = DIR_BWD;
      end
      default: begin
        b.pin_a = 1'b0; b.pin_b = 1'b0; b.pulse_us = 10'd0; b.direction = DIR_ZERO;
      end
    endcase
    last_dir = b.direction;
    beats_due.push_back(b);
  endfunction

  // sender
  always @(posedge clk) begin
    logic offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        map_command(cur_cmd);
        offer = 1'b0;
      end
      if (!offer && cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_cmd = cmd_backlog.pop_front();
        req_type <= cur_cmd.req_type;
        drive_mode <= cur_cmd.drive_mode;
        duty_request <= cur_cmd.duty;
        offer = 1'b1;
      end
      in_valid <= offer;
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= 600;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    bridge_beat_t got;
    bridge_beat_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{pin_a: pin_a, pin_b: pin_b, pulse_us: pulse_us, direction: direction,
                hold_us: hold_us, last_result: last_result};
        if (beats_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected beat: a=%0d b=%0d pulse=%0d dir=%0d hold=%0d last=%0d",
                     got.pin_a, got.pin_b, got.pulse_us, $signed(got.direction),
                     got.hold_us, got.last_result);
        end else begin
          want = beats_due.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch at %0t: exp a=%0d b=%0d pulse=%0d dir=%0d hold=%0d last=%0d",
                       $realtime, want.pin_a, want.pin_b, want.pulse_us,
                       $signed(want.direction), want.hold_us, want.last_result,
                       " / got a=%0d b=%0d pulse=%0d dir=%0d hold=%0d last=%0d",
                       got.pin_a, got.pin_b, got.pulse_us, $signed(got.direction),
                       got.hold_us, got.last_result);
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_SWAP: swap_en = val[0];
      CFG_MIN:  lvl_min = val[14:0];
      CFG_MAX:  lvl_max = val[14:0];
      default:  guard_us = val;
    endcase
  endtask

  task automatic apply_settings(logic s, logic [14:0] mn, logic [14:0] mx, logic [15:0] g);
    cfg_write(CFG_SWAP, {15'h0, s});
    cfg_write(CFG_MIN, {1'b0, mn});
    cfg_write(CFG_MAX, {1'b0, mx});
    cfg_write(CFG_GUARD, g);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic void push_cmd(logic rt, logic [1:0] m, logic [15:0] d);
    motor_cmd_t c;
    c = '{req_type: rt, drive_mode: m, duty: d};
    cmd_backlog.push_back(c);
  endfunction

  task automatic drain();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid || beats_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  function automatic motor_cmd_t rand_cmd(motor_cmd_t prev);
    motor_cmd_t c;
    logic [15:0] d;
    c.req_type = 1'($urandom_range(1));
    c.drive_mode = ($urandom_range(9) == 0) ? MODE_RSVD : 2'($urandom_range(MODE_BWD));
    // keep the same explicit mode now and then so the guard is skipped
    if (prev.req_type == 1'b0 && $urandom_range(99) < 40) begin
      c.req_type = 1'b0;
      c.drive_mode = prev.drive_mode;
    end
    case ($urandom_range(7))
      0: d = 16'h8000;
      1: d = 16'h7FFF;
      2: d = 16'h0000;
      3: begin
        d = 16'($urandom_range(300));
        if ($urandom_range(1)) d = -d;
      end
      4, 5: begin
        d = 16'($urandom_range(lvl_max));
        if ($urandom_range(1)) d = -d;
      end
      default: d = 16'($urandom);
    endcase
    c.duty = d;
    return c;
  endfunction

  initial begin
    motor_cmd_t  prev;
    logic [14:0] mx;
    logic [14:0] mn;
    logic [15:0] g;
    int          third;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 34;
    recv_idle_pct = 73;

    // reset settings: no guard, no remap, max 255
    push_cmd(1'b0, MODE_STOP, 16'd100);
    push_cmd(1'b0, MODE_FWD,  16'd255);
    push_cmd(1'b0, MODE_FWD,  16'd0);
    push_cmd(1'b0, MODE_BWD,  16'h7FFF);
    push_cmd(1'b0, MODE_BWD,  16'h8000);
    push_cmd(1'b0, MODE_RSVD, 16'd50);
    push_cmd(1'b1, MODE_STOP, 16'd1);
    push_cmd(1'b1, MODE_FWD,  16'hFFFF);
    push_cmd(1'b1, MODE_BWD,  16'd0);
    push_cmd(1'b1, MODE_RSVD, 16'h8000);
    push_cmd(1'b1, MODE_STOP, 16'h7FFF);
    drain();

    // swapped, remap, guard on
    apply_settings(1'b1, 15'd40, 15'd200, 16'd500);
    push_cmd(1'b0, MODE_FWD,  16'd100);
    push_cmd(1'b0, MODE_FWD,  16'd100);
    push_cmd(1'b0, MODE_BWD,  16'hFFFB);
    push_cmd(1'b0, MODE_RSVD, 16'd10);
    push_cmd(1'b0, MODE_STOP, 16'd3);
    push_cmd(1'b1, MODE_STOP, 16'd300);
    push_cmd(1'b0, MODE_FWD,  16'd0);
    push_cmd(1'b1, MODE_FWD,  16'hFFFF);
    drain();

    // zero max with min above it
    apply_settings(1'b0, 15'd300, 15'd0, 16'd1);
    push_cmd(1'b0, MODE_FWD,  16'd1000);
    push_cmd(1'b1, MODE_FWD,  16'hFFF9);
    push_cmd(1'b0, MODE_STOP, 16'd0);
    push_cmd(1'b0, MODE_BWD,  16'h8000);
    drain();

    prev = '{req_type: 1'b1, drive_mode: MODE_STOP, duty: 16'h0};
    for (int p = 0; p < 16; p++) begin
      third = p * 3 / 16;
      send_idle_pct = (third == 0) ? 34 : (third == 1) ? 73 : 0;
      recv_idle_pct = (third == 0) ? 73 : (third == 1) ? 34 : 0;
      case (p)
        0: apply_settings(1'b1, 15'h7FFF, 15'h7FFF, 16'hFFFF);
        1: apply_settings(1'b0, 15'd0, 15'd1, 16'd0);
        2: apply_settings(1'b1, 15'h7FFF, 15'd1000, 16'd2);
        default: begin
          case ($urandom_range(3))
            0: mx = 15'd1;
            1: mx = 15'h7FFF;
            2: mx = MAX_LEVEL_RST;
            default: mx = 15'($urandom_range(32767, 1));
          endcase
          case ($urandom_range(3))
            0: mn = 15'd0;
            1: mn = 15'($urandom_range(32767));
            default: mn = 15'($urandom_range(mx));
          endcase
          case ($urandom_range(3))
            0: g = 16'd0;
            1: g = 16'hFFFF;
            default: g = 16'($urandom_range(65535, 1));
          endcase
          apply_settings(1'($urandom_range(1)), mn, mx, g);
        end
      endcase
      if (p == 14) hold_req++;
      for (int k = 0; k < 96; k++) begin
        prev = rand_cmd(prev);
        cmd_backlog.push_back(prev);
      end
      drain();
    end

    repeat (100) @(negedge clk);
    if (mismatch_cnt == 0 && beats_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
